// ===== hdl/rbe_pkg.sv =====
// Shared types and constants of the byte-wise rANS encoder.
`default_nettype none
package rbe_pkg;

  localparam int OP_W           = 2;
  localparam int SYM_W          = 8;
  localparam int FREQ_W         = 15;
  localparam int BYTE_W         = 8;
  localparam int VALUE_W        = 32;
  localparam int TOTAL_W        = 23;
  localparam int FLUSH_BYTES    = 8;
  localparam int DIV_DIGIT_BITS = 2;

  localparam int SCALE_BITS_DEF       = 14;
  localparam int LOWER_BOUND_BITS_DEF = 24;
  localparam int ALPHABET_SIZE_DEF    = 256;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } rbe_tbl_cmd_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [FREQ_W-1:0]  divisor;
  } rbe_div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [FREQ_W-1:0]  remainder;
  } rbe_div_rsp_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } rbe_push_t;

endpackage
`default_nettype wire

// ===== hdl/rbe_if.sv =====
// Valid/ready channel interfaces for input items and emitted bytes.
`default_nettype none
interface rbe_in_if import rbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SYM_W-1:0]  symbol;
  logic [FREQ_W-1:0] frequency;

  modport source (output valid, output op, output symbol, output frequency, input ready);
  modport sink (input valid, input op, input symbol, input frequency, output ready);
endinterface

interface rbe_out_if import rbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/rbe_table.sv =====
// Frequency and cumulative start table with the running total for loads.
`default_nettype none
module rbe_table import rbe_pkg::*; #(
  parameter int SCALE_BITS    = SCALE_BITS_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rbe_tbl_cmd_t          cmd,
  input  wire logic [SYM_W-1:0]      symbol,
  input  wire logic [FREQ_W-1:0]     frequency,
  output logic      [FREQ_W-1:0]     rd_freq,
  output logic      [SCALE_BITS-1:0] rd_cum
);

  localparam int IDX_W   = $clog2(ALPHABET_SIZE);
  localparam int ENTRY_W = FREQ_W + SCALE_BITS;

  logic [ENTRY_W-1:0] mem [ALPHABET_SIZE];
  logic [ENTRY_W-1:0] rd_data;
  logic [TOTAL_W-1:0] running_total;
  logic [TOTAL_W-1:0] base;
  logic [FREQ_W-1:0]  freq_clamped;
  logic [IDX_W-1:0]   idx;

  assign idx          = symbol[IDX_W-1:0];
  assign freq_clamped = (frequency == '0) ? FREQ_W'(1) : frequency;
  // Restart the running total at symbol zero.
  assign base         = (symbol == '0) ? '0 : running_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (cmd.wr) begin
      running_total <= base + TOTAL_W'(freq_clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[idx] <= {freq_clamped, base[SCALE_BITS-1:0]};
    end
    if (cmd.rd) begin
      rd_data <= mem[idx];
    end
  end

  assign rd_freq = rd_data[ENTRY_W-1:SCALE_BITS];
  assign rd_cum  = rd_data[SCALE_BITS-1:0];

endmodule
`default_nettype wire

// ===== hdl/rbe_divider.sv =====
// Restoring divider, 32 by 15 bits, two quotient bits per cycle.
`default_nettype none
module rbe_divider import rbe_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire rbe_div_req_t req,
  output rbe_div_rsp_t      rsp
);

  localparam int DIV_STEPS = VALUE_W / DIV_DIGIT_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  logic [VALUE_W-1:0] quo, quo_next;
  logic [FREQ_W-1:0]  rem, rem_next;
  logic [FREQ_W-1:0]  div;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;

  always_comb begin
    logic [FREQ_W:0] t;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_DIGIT_BITS; i++) begin
      t        = {rem_next, quo_next[VALUE_W-1]};
      quo_next = {quo_next[VALUE_W-2:0], 1'b0};
      if (t >= {1'b0, div}) begin
        rem_next    = FREQ_W'(t - {1'b0, div});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = t[FREQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      div <= req.divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

// ===== hdl/rbe_out_stage.sv =====
// Output register between the coder and the byte channel.
`default_nettype none
module rbe_out_stage import rbe_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rbe_push_t push,
  output logic           free,
  rbe_out_if.source      out
);

  logic              valid;
  logic [BYTE_W-1:0] data;
  logic              last;

  assign free = !valid || out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push.valid) begin
      data <= push.data;
      last <= push.last;
    end
  end

  assign out.valid     = valid;
  assign out.out_byte  = data;
  assign out.last_byte = last;

endmodule
`default_nettype wire

// ===== hdl/rbe_coder.sv =====
// Coder sequencer: value register, byte-serial renormalization and flush.
`default_nettype none
module rbe_coder import rbe_pkg::*; #(
  parameter int SCALE_BITS       = SCALE_BITS_DEF,
  parameter int LOWER_BOUND_BITS = LOWER_BOUND_BITS_DEF,
  parameter int ALPHABET_SIZE    = ALPHABET_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_accept,
  input  wire logic [OP_W-1:0]       in_op,
  input  wire logic [SYM_W-1:0]      in_symbol,
  output logic                       ready,
  output rbe_tbl_cmd_t               tbl,
  input  wire logic [FREQ_W-1:0]     rd_freq,
  input  wire logic [SCALE_BITS-1:0] rd_cum,
  output rbe_div_req_t               div_req,
  input  wire rbe_div_rsp_t          div_rsp,
  input  wire logic                  push_free,
  output rbe_push_t                  push
);

  localparam int RENORM_SHIFT = LOWER_BOUND_BITS - SCALE_BITS + BYTE_W;
  localparam logic [VALUE_W-1:0] VALUE_INIT = VALUE_W'(1) << LOWER_BOUND_BITS;
  localparam int FCNT_W = $clog2(FLUSH_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RENORM = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [VALUE_W-1:0] value, value_next;
  logic [FCNT_W-1:0]  fcnt, fcnt_next;
  logic               sym_ok;
  logic [FREQ_W-1:0]  fs;
  logic [VALUE_W-1:0] fs_wide;
  logic               renorm_go;
  logic               renorm_more;

  assign sym_ok = 32'(in_symbol) < ALPHABET_SIZE;
  assign ready  = (state == ST_IDLE);

  assign tbl.wr = in_accept && (in_op == OP_LOAD) && sym_ok;
  assign tbl.rd = in_accept && (in_op == OP_ENCODE) && sym_ok;

  // Treat a zero entry as one.
  assign fs          = (rd_freq == '0) ? FREQ_W'(1) : rd_freq;
  assign fs_wide     = VALUE_W'(fs);
  // value >= fs << shift, and the same one byte further down.
  assign renorm_go   = (value >> RENORM_SHIFT) >= fs_wide;
  assign renorm_more = (value >> (RENORM_SHIFT + BYTE_W)) >= fs_wide;

  always_comb begin
    state_next       = state;
    value_next       = value;
    fcnt_next        = fcnt;
    div_req.start    = 1'b0;
    div_req.dividend = value;
    div_req.divisor  = fs;
    push.valid       = 1'b0;
    push.data        = value[BYTE_W-1:0];
    push.last        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept && (in_op == OP_ENCODE) && sym_ok) begin
          state_next = ST_RENORM;
        end else if (in_accept && (in_op == OP_FLUSH)) begin
          fcnt_next  = '0;
          state_next = ST_FLUSH;
        end
      end
      ST_RENORM: begin
        if (renorm_go) begin
          if (push_free) begin
            push.valid = 1'b1;
            push.last  = !renorm_more;
            value_next = value >> BYTE_W;
          end
        end else begin
          div_req.start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          value_next = (div_rsp.quotient << SCALE_BITS) + VALUE_W'(div_rsp.remainder)
                       + VALUE_W'(rd_cum);
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (push_free) begin
          push.valid = 1'b1;
          push.last  = (fcnt == FCNT_W'(FLUSH_BYTES - 1));
          value_next = value >> BYTE_W;
          fcnt_next  = fcnt + FCNT_W'(1);
          if (fcnt == FCNT_W'(FLUSH_BYTES - 1)) begin
            value_next = VALUE_INIT;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      value <= VALUE_INIT;
      fcnt  <= '0;
    end else begin
      state <= state_next;
      value <= value_next;
      fcnt  <= fcnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rans_byte_encoder_top.sv =====
// Top level of the byte-wise rANS encoder.
// This block encodes bytes with range ANS at a 2^SCALE_BITS frequency scale and a
// 32-bit coder value. Each input transaction carries an op: load writes one symbol's
// frequency (zero becomes one), the cumulative start taken from a running total that
// restarts at symbol zero; the user is to load in ascending symbol order, which the
// block does not enforce; encode takes one symbol, in reverse data order, and pushes
// 0 to 2 renormalization bytes low first; flush pushes 8 bytes, the 32-bit value low
// first and then zeros, and restarts the coder. last_byte marks the final byte of
// each transaction; the host reverses the whole byte stream. Loads, op code 3 and
// encodes of symbols at or above ALPHABET_SIZE give no bytes. An encode goes through
// the table read, the renormalization bytes shifted out of the value register, and
// the divider, which retires two quotient bits per cycle. Items are handled one at a
// time; stalls on the byte channel stretch the byte phases. Encoding a symbol that
// was never loaded gives an unspecified result.
`default_nettype none
module rans_byte_encoder_top import rbe_pkg::*; #(
  parameter int SCALE_BITS       = SCALE_BITS_DEF,
  parameter int LOWER_BOUND_BITS = LOWER_BOUND_BITS_DEF,
  parameter int ALPHABET_SIZE    = ALPHABET_SIZE_DEF
) (
  input wire logic clk,
  input wire logic rst,
  rbe_in_if.sink   in_ch,
  rbe_out_if.source out_ch
);

  rbe_tbl_cmd_t          tbl;
  rbe_div_req_t          div_req;
  rbe_div_rsp_t          div_rsp;
  rbe_push_t             push;
  logic                  push_free;
  logic                  in_accept;
  logic [FREQ_W-1:0]     rd_freq;
  logic [SCALE_BITS-1:0] rd_cum;

  // Accept a transaction only while the coder is idle.
  assign in_accept = in_ch.valid && in_ch.ready;

  rbe_table #(
    .SCALE_BITS    (SCALE_BITS),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (tbl),
    .symbol    (in_ch.symbol),
    .frequency (in_ch.frequency),
    .rd_freq   (rd_freq),
    .rd_cum    (rd_cum)
  );

  rbe_coder #(
    .SCALE_BITS       (SCALE_BITS),
    .LOWER_BOUND_BITS (LOWER_BOUND_BITS),
    .ALPHABET_SIZE    (ALPHABET_SIZE)
  ) u_coder (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_op     (in_ch.op),
    .in_symbol (in_ch.symbol),
    .ready     (in_ch.ready),
    .tbl       (tbl),
    .rd_freq   (rd_freq),
    .rd_cum    (rd_cum),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .push_free (push_free),
    .push      (push)
  );

  // Divider: value / freq gives quotient and remainder for the update.
  rbe_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Hold each pushed byte until the sink takes it.
  rbe_out_stage u_out_stage (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .free (push_free),
    .out  (out_ch)
  );

endmodule
`default_nettype wire

// ===== bench/tb_rans_byte_encoder_top.sv =====
// Self-checking testbench for the byte-wise rANS encoder top level.
`timescale 1ns / 1ps
module tb_rans_byte_encoder_top;
  import rbe_pkg::*;

  // Op code 3 has no enum member in the package; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam longint unsigned VALUE_INIT  = 64'd1 << LOWER_BOUND_BITS_DEF;
  localparam longint unsigned SCALE_TOTAL = 64'd1 << SCALE_BITS_DEF;
  localparam int unsigned     MAX_FREQ    = 1 << SCALE_BITS_DEF;

  // Slowest legal run is roughly 400 transactions, each with a send gap, the work
  // of the item and up to 8 bytes, each stalled on the byte side.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Drain time after the last owed byte, well past the longest encode.
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] frequency;
  } coder_cmd_t;

  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } coded_byte_t;

  logic clk;
  logic rst;

  rbe_in_if  in_ch ();
  rbe_out_if out_ch ();

  rans_byte_encoder_top dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Commands waiting for the driver, and bytes the encoder still owes us.
  coder_cmd_t  pending_cmds[$];
  coded_byte_t expected_bytes[$];

  // Private copy of the encoder state, advanced on every accepted transaction.
  logic [VALUE_W-1:0] coder_val;
  logic [FREQ_W-1:0]  freq_tbl[256];
  logic [13:0]        cum_tbl[256];
  logic [TOTAL_W-1:0] run_total;

  // Symbols whose table entries have been written; only these may be encoded.
  logic [SYM_W-1:0] loaded_syms[$];
  bit               sym_loaded[256];

  int unsigned accepted_cmds;
  int unsigned total_cmds;
  int unsigned error_count;
  int unsigned cycle_count;

  int unsigned send_gap;
  int unsigned recv_stall;
  bit          send_calm;
  bit          recv_calm;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Idle gap length: mostly none or short, now and then a long one. In calm
  // mode there is no idling at all, which gives back-to-back stretches.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Queue one command; track loads so encodes only touch written entries.
  function automatic void add_cmd(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                  logic [FREQ_W-1:0] freq);
    coder_cmd_t cmd;
    cmd.op        = op;
    cmd.symbol    = sym;
    cmd.frequency = freq;
    pending_cmds.insert(pending_cmds.size(), cmd);
    if (op == OP_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.insert(loaded_syms.size(), sym);
    end
  endfunction

  function automatic logic [SYM_W-1:0] any_loaded_sym();
    return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
  endfunction

  function automatic void push_expected(logic [BYTE_W-1:0] value, logic last);
    coded_byte_t b;
    b.value = value;
    b.last  = last;
    expected_bytes.insert(expected_bytes.size(), b);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: apply one accepted command to the private state and queue the
  // bytes it must push, in push order.
  // ---------------------------------------------------------------------------
  function automatic void predict_coded_bytes(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                              logic [FREQ_W-1:0] freq);
    longint unsigned x;
    longint unsigned fs;
    longint unsigned limit;
    logic [FREQ_W-1:0] f;
    int unsigned pushed;
    pushed = 0;
    case (op)
      OP_LOAD: begin
        // Clamp zero to one; symbol 0 restarts the cumulative count.
        f = (freq == '0) ? FREQ_W'(1) : freq;
        if (sym == '0) run_total = '0;
        freq_tbl[sym] = f;
        cum_tbl[sym]  = run_total[13:0];
        run_total     = run_total + TOTAL_W'(f);
      end
      OP_ENCODE: begin
        x  = coder_val;
        fs = freq_tbl[sym];
        if (fs == 0) fs = 1;
        limit = (VALUE_INIT / SCALE_TOTAL) * 256 * fs;
        // Renormalize: shift out low bytes until the value fits under the limit.
        while (x >= limit && pushed < FLUSH_BYTES) begin
          push_expected(x[7:0], 1'b0);
          x = x >> 8;
          pushed++;
        end
        x = (x / fs) * SCALE_TOTAL + (x % fs) + longint'(cum_tbl[sym]);
        coder_val = x[VALUE_W-1:0];
        if (pushed > 0) expected_bytes[$].last = 1'b1;
      end
      OP_FLUSH: begin
        // Eight bytes low first; the upper four are always zero.
        for (int i = 0; i < FLUSH_BYTES; i++) begin
          push_expected((i < 4) ? coder_val[8*i +: 8] : 8'h00, i == FLUSH_BYTES - 1);
        end
        coder_val = VALUE_W'(VALUE_INIT);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pop the next command when the channel is free, idling at random.
  // valid gets at most one nonblocking write per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_cmds
    coder_cmd_t cmd;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap    <= 0;
      send_calm   <= 1'b0;
    end else begin
      if ($urandom_range(0, 59) == 0) send_calm <= !send_calm;
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap    <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          cmd = pending_cmds.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.op        <= cmd.op;
          in_ch.symbol    <= cmd.symbol;
          in_ch.frequency <= cmd.frequency;
          send_gap        <= pick_gap(send_calm);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted command, then check every accepted byte
  // against the oldest expectation. Handle the input side first so the order
  // of the two channels within one edge never matters. Also drive a randomly
  // stalling ready on the byte channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_ports
    coded_byte_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_stall   <= 0;
      recv_calm    <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_coded_bytes(in_ch.op, in_ch.symbol, in_ch.frequency);
        accepted_cmds++;
      end

      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected byte: expected none, actual out_byte %02h last_byte %0b",
                   $time, out_ch.out_byte, out_ch.last_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want.value) begin
            error_count++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.value, out_ch.out_byte);
          end
          if (out_ch.last_byte !== want.last) begin
            error_count++;
            $display("%0t: last_byte mismatch: expected %0b, actual %0b",
                     $time, want.last, out_ch.last_byte);
          end
        end
      end

      // Stall the byte side for a random gap from pick_gap, then open it again.
      if ($urandom_range(0, 59) == 0) recv_calm <= !recv_calm;
      if (recv_stall > 0) begin
        out_ch.ready <= 1'b0;
        recv_stall   <= recv_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        recv_stall   <= pick_gap(recv_calm);
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d commands accepted, %0d bytes outstanding",
               $time, accepted_cmds, expected_bytes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [SYM_W-1:0]  table_syms[$];
    logic [FREQ_W-1:0] f;
    int unsigned n_syms;
    int unsigned next_sym;
    int unsigned max_step;
    int unsigned remaining;
    int unsigned run_len;
    int unsigned roll;
    bit balanced;

    // Known values on every input before the first edge.
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_LOAD;
    in_ch.symbol     = '0;
    in_ch.frequency  = '0;
    out_ch.ready     = 1'b0;
    accepted_cmds    = 0;
    error_count      = 0;
    cycle_count      = 0;
    coder_val        = VALUE_W'(VALUE_INIT);
    run_total        = '0;
    foreach (freq_tbl[i]) begin
      freq_tbl[i]   = '0;
      cum_tbl[i]    = '0;
      sym_loaded[i] = 1'b0;
    end

    // Directed part. Zero frequency gets clamped; 16384 is the largest legal
    // value and sets the top frequency bit; symbol 255 is the top of the table.
    add_cmd(OP_LOAD, 8'd0, 15'd0);
    add_cmd(OP_LOAD, 8'd1, 15'(MAX_FREQ));
    add_cmd(OP_LOAD, 8'd2, 15'd1);
    add_cmd(OP_LOAD, 8'd3, 15'd5461);
    add_cmd(OP_LOAD, 8'd255, 15'd10922);
    // Full-scale frequency: no renormalization bytes.
    add_cmd(OP_ENCODE, 8'd1, 15'h7fff & 15'(MAX_FREQ));
    // Frequency one: lowest limit, one then two bytes pushed.
    add_cmd(OP_ENCODE, 8'd0, 15'd0);
    add_cmd(OP_ENCODE, 8'd0, 15'h3fff);
    add_cmd(OP_ENCODE, 8'd2, 15'd0);
    add_cmd(OP_ENCODE, 8'd255, 15'd0);
    add_cmd(OP_ENCODE, 8'd3, 15'd0);
    // Unused op code: no bytes, no state change.
    add_cmd(OP_UNUSED, 8'hff, 15'(MAX_FREQ));
    add_cmd(OP_FLUSH, 8'd0, 15'd0);
    // Flush at the lower bound, right after a restart.
    add_cmd(OP_FLUSH, 8'hff, 15'h3fff);
    // Reload symbol 0 mid-stream, which restarts the cumulative count, then load
    // sparse symbols with large frequencies so the table no longer sums to full scale.
    add_cmd(OP_LOAD, 8'd0, 15'd12000);
    add_cmd(OP_LOAD, 8'd200, 15'(MAX_FREQ));
    add_cmd(OP_LOAD, 8'd201, 15'(MAX_FREQ));
    add_cmd(OP_ENCODE, 8'd201, 15'd0);
    add_cmd(OP_ENCODE, 8'd0, 15'd0);
    add_cmd(OP_ENCODE, 8'd200, 15'd0);
    add_cmd(OP_UNUSED, 8'd0, 15'd0);
    add_cmd(OP_FLUSH, 8'd0, 15'd0);

    // Random part: mostly well-formed blocks (ascending table load, a run of
    // encodes over that table, a flush), with noise mixed in.
    while (pending_cmds.size() < 300) begin
      if ($urandom_range(0, 99) < 85) begin
        n_syms   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        max_step = (n_syms > 8) ? 6 : 80;
        table_syms = {};
        next_sym   = 0;
        while (table_syms.size() < n_syms && next_sym <= 255) begin
          table_syms.insert(table_syms.size(), SYM_W'(next_sym));
          next_sym += $urandom_range(1, max_step);
        end
        if ($urandom_range(0, 7) == 0 && table_syms[$] != 8'd255)
          table_syms.insert(table_syms.size(), 8'd255);

        // Either split full scale over the table, or load arbitrary values.
        balanced  = ($urandom_range(0, 3) != 0);
        remaining = MAX_FREQ;
        foreach (table_syms[k]) begin
          if (balanced) begin
            if (k == table_syms.size() - 1) f = FREQ_W'(remaining);
            else f = FREQ_W'($urandom_range(1, remaining - (table_syms.size() - 1 - k)));
            remaining -= f;
          end else begin
            roll = $urandom_range(0, 9);
            if (roll == 0) f = '0;
            else if (roll == 1) f = FREQ_W'(MAX_FREQ);
            else f = FREQ_W'($urandom_range(0, MAX_FREQ));
          end
          add_cmd(OP_LOAD, table_syms[k], f);
        end

        run_len = $urandom_range(3, 25);
        for (int j = 0; j < run_len; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 4) begin
            add_cmd(OP_UNUSED, SYM_W'($urandom()), FREQ_W'($urandom_range(0, MAX_FREQ)));
          end else if (roll < 8) begin
            add_cmd(OP_LOAD, SYM_W'($urandom()), FREQ_W'($urandom_range(0, MAX_FREQ)));
          end else if (roll < 12) begin
            add_cmd(OP_ENCODE, any_loaded_sym(), FREQ_W'($urandom_range(0, MAX_FREQ)));
          end else begin
            add_cmd(OP_ENCODE, table_syms[$urandom_range(0, table_syms.size() - 1)],
                    FREQ_W'($urandom_range(0, MAX_FREQ)));
          end
        end
        // Skip the flush now and then so the value carries into the next table.
        if ($urandom_range(0, 99) < 85) add_cmd(OP_FLUSH, SYM_W'($urandom()), FREQ_W'($urandom()));
      end else begin
        // Noise burst.
        repeat ($urandom_range(1, 4)) begin
          roll = $urandom_range(0, 2);
          if (roll == 0) add_cmd(OP_UNUSED, SYM_W'($urandom()), FREQ_W'($urandom()));
          else if (roll == 1) add_cmd(OP_FLUSH, SYM_W'($urandom()), FREQ_W'($urandom()));
          else add_cmd(OP_LOAD, SYM_W'($urandom()), FREQ_W'($urandom_range(0, MAX_FREQ)));
        end
      end
    end
    total_cmds = pending_cmds.size();

    // Hold reset, then release it once.
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every owed byte to arrive, then
    // drain so any stray late byte gets caught by the monitor.
    wait (accepted_cmds == total_cmds && expected_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rbe_pkg.sv
hdl/rbe_if.sv
hdl/rbe_table.sv
hdl/rbe_divider.sv
hdl/rbe_out_stage.sv
hdl/rbe_coder.sv
hdl/rans_byte_encoder_top.sv
bench/tb_rans_byte_encoder_top.sv
